// File: rtl/utf8_offset_to_utf16_position_core_defines.svh
// Assertion macros used by the checker file of the position core.
`ifndef UTF8_OFFSET_TO_UTF16_POSITION_CORE_DEFINES_SVH
`define UTF8_OFFSET_TO_UTF16_POSITION_CORE_DEFINES_SVH

// Concurrent check that is switched off while reset is asserted.
`define U8U16_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that also holds across reset.
`define U8U16_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/u8u16_pkg.sv
// Shared types and byte constants for the UTF-8 to UTF-16 position core.
package u8u16_pkg;

    localparam int OUT_WIDTH = 32;

    localparam logic [7:0] C_LF          = 8'h0A;
    localparam logic [7:0] C_CR          = 8'h0D;
    localparam logic [7:0] C_MASK_LEAD2  = 8'hE0;
    localparam logic [7:0] C_CODE_LEAD2  = 8'hC0;
    localparam logic [7:0] C_MASK_LEAD3  = 8'hF0;
    localparam logic [7:0] C_CODE_LEAD3  = 8'hE0;
    localparam logic [7:0] C_MASK_LEAD4  = 8'hF8;
    localparam logic [7:0] C_CODE_LEAD4  = 8'hF0;
    localparam logic [7:0] C_PLANE_MASK  = 8'h07;
    localparam logic [7:0] C_CONT_MASK   = 8'h3F;
    localparam logic [7:0] C_PLANE_MIN   = 8'h10;

    // Column units a byte contributes and continuation bytes it announces.
    typedef struct packed {
        logic [1:0] units;
        logic [1:0] swallow;
    } t_lead_info;

endpackage

// File: rtl/utf8_offset_to_utf16_position_core.sv
// Top level of the UTF-8 byte offset to UTF-16 line and column position core.
//
// The input channel carries one byte of UTF-8 text per transfer, together
// with the byte after it, the number of bytes left in the buffer (saturated
// at three), a start-of-text flag and a query-end flag. Every input transfer
// produces exactly one result transfer with the line number and UTF-16
// column reached after that byte, and the query-end flag echoed as
// answer_ready so the consumer can pick out the answer.
// Both channels use valid and stall; a transfer happens on a clock edge with
// valid high and stall low.
// An accepted byte waits in the input register, and its result is then
// offered from the result register. Throughput is one byte per cycle
// while the receiver does not stall; the counter update is a single
// adder and compare per counter between the input and result registers.
// When the receiver stalls, the result register holds its transfer and the
// input register can still take one more byte; only when both are full is
// the input stall raised.
// Synchronous active-low reset empties both registers and clears the line,
// column, continuation and carriage-return state.
module utf8_offset_to_utf16_position_core #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [7:0]                      i_text_byte,
    input  logic [7:0]                      i_following_byte,
    input  logic [1:0]                      i_bytes_after,
    input  logic                            i_start_of_text,
    input  logic                            i_query_end,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [u8u16_pkg::OUT_WIDTH-1:0] o_line_number,
    output logic [u8u16_pkg::OUT_WIDTH-1:0] o_utf16_column,
    output logic                            o_answer_ready
);
    import u8u16_pkg::*;

    // Input register.
    logic                   r_in_valid;
    logic [7:0]             r_text_byte;
    logic [7:0]             r_following_byte;
    logic [1:0]             r_bytes_after;
    logic                   r_start_of_text;
    logic                   r_query_end;

    // Position state.
    logic [COUNT_WIDTH-1:0] r_line;
    logic [COUNT_WIDTH-1:0] r_column;
    logic [1:0]             r_swallow;
    logic                   r_after_cr;
    logic [COUNT_WIDTH-1:0] n_line;
    logic [COUNT_WIDTH-1:0] n_column;
    logic [1:0]             n_swallow;
    logic                   n_after_cr;

    // Result register.
    logic                   r_out_valid;
    logic [OUT_WIDTH-1:0]   r_out_line;
    logic [OUT_WIDTH-1:0]   r_out_column;
    logic                   r_out_answer;
    logic [OUT_WIDTH-1:0]   n_out_line;
    logic [OUT_WIDTH-1:0]   n_out_column;

    logic                   out_free;
    logic                   fire;
    logic                   in_accept;
    t_lead_info             lead;

    // The result register is free when empty or when its transfer completes.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    u8u16_lead u_lead (
        .i_text_byte      (r_text_byte),
        .i_following_byte (r_following_byte),
        .i_bytes_after    (r_bytes_after),
        .o_lead           (lead)
    );

    u8u16_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .i_line           (r_line),
        .i_column         (r_column),
        .i_swallow        (r_swallow),
        .i_after_cr       (r_after_cr),
        .i_text_byte      (r_text_byte),
        .i_start_of_text  (r_start_of_text),
        .i_lead           (lead),
        .o_line           (n_line),
        .o_column         (n_column),
        .o_swallow        (n_swallow),
        .o_after_cr       (n_after_cr),
        .o_line_clamped   (n_out_line),
        .o_column_clamped (n_out_column)
    );

    // Control and position state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_line      <= '0;
            r_column    <= '0;
            r_swallow   <= 2'd0;
            r_after_cr  <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (fire) begin
                r_line     <= n_line;
                r_column   <= n_column;
                r_swallow  <= n_swallow;
                r_after_cr <= n_after_cr;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_text_byte      <= i_text_byte;
            r_following_byte <= i_following_byte;
            r_bytes_after    <= i_bytes_after;
            r_start_of_text  <= i_start_of_text;
            r_query_end      <= i_query_end;
        end
        if (fire) begin
            r_out_line   <= n_out_line;
            r_out_column <= n_out_column;
            r_out_answer <= r_query_end;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_line_number  = r_out_line;
    assign o_utf16_column = r_out_column;
    assign o_answer_ready = r_out_answer;

endmodule

// File: rtl/u8u16_lead.sv
// Lead byte decoder: UTF-16 units and continuation count for one byte.
module u8u16_lead (
    input  logic [7:0]             i_text_byte,
    input  logic [7:0]             i_following_byte,
    input  logic [1:0]             i_bytes_after,
    output u8u16_pkg::t_lead_info  o_lead
);
    import u8u16_pkg::*;

    always_comb begin
        o_lead.units   = 2'd1;
        o_lead.swallow = 2'd0;
        if (!i_text_byte[7]) begin
            o_lead.units = 2'd1;
        end else if ((i_text_byte & C_MASK_LEAD2) == C_CODE_LEAD2 && i_bytes_after >= 2'd1) begin
            o_lead.swallow = 2'd1;
        end else if ((i_text_byte & C_MASK_LEAD3) == C_CODE_LEAD3 && i_bytes_after >= 2'd2) begin
            o_lead.swallow = 2'd2;
        end else if ((i_text_byte & C_MASK_LEAD4) == C_CODE_LEAD4 && i_bytes_after == 2'd3) begin
            o_lead.swallow = 2'd3;
            // Code points above the basic plane need a surrogate pair.
            if ((i_text_byte & C_PLANE_MASK) != 8'd0
                    || (i_following_byte & C_CONT_MASK) >= C_PLANE_MIN) begin
                o_lead.units = 2'd2;
            end
        end
    end

endmodule

// File: rtl/u8u16_step.sv
// Next-state logic for the line and column counters, with output clamping.
module u8u16_step #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic [COUNT_WIDTH-1:0]          i_line,
    input  logic [COUNT_WIDTH-1:0]          i_column,
    input  logic [1:0]                      i_swallow,
    input  logic                            i_after_cr,
    input  logic [7:0]                      i_text_byte,
    input  logic                            i_start_of_text,
    input  u8u16_pkg::t_lead_info           i_lead,
    output logic [COUNT_WIDTH-1:0]          o_line,
    output logic [COUNT_WIDTH-1:0]          o_column,
    output logic [1:0]                      o_swallow,
    output logic                            o_after_cr,
    output logic [u8u16_pkg::OUT_WIDTH-1:0] o_line_clamped,
    output logic [u8u16_pkg::OUT_WIDTH-1:0] o_column_clamped
);
    import u8u16_pkg::*;

    logic [COUNT_WIDTH-1:0] base_line;
    logic [COUNT_WIDTH-1:0] cur_column;
    logic [1:0]             cur_swallow;
    logic                   cur_after_cr;
    logic [COUNT_WIDTH:0]   line_sum;
    logic [COUNT_WIDTH:0]   column_sum;
    logic [COUNT_WIDTH-1:0] line_inc;
    logic [COUNT_WIDTH-1:0] column_inc;

    // A start-of-text byte sees cleared state.
    assign base_line    = i_start_of_text ? '0 : i_line;
    assign cur_column   = i_start_of_text ? '0 : i_column;
    assign cur_swallow  = i_start_of_text ? 2'd0 : i_swallow;
    assign cur_after_cr = i_start_of_text ? 1'b0 : i_after_cr;

    assign line_sum   = {1'b0, base_line} + (COUNT_WIDTH + 1)'(1);
    assign column_sum = {1'b0, cur_column} + (COUNT_WIDTH + 1)'(i_lead.units);
    assign line_inc   = line_sum[COUNT_WIDTH] ? '1 : line_sum[COUNT_WIDTH-1:0];
    assign column_inc = column_sum[COUNT_WIDTH] ? '1 : column_sum[COUNT_WIDTH-1:0];

    always_comb begin
        o_line     = base_line;
        o_column   = cur_column;
        o_swallow  = cur_swallow;
        o_after_cr = 1'b0;
        if (cur_swallow != 2'd0) begin
            o_swallow  = cur_swallow - 2'd1;
            o_after_cr = cur_after_cr;
        end else if (cur_after_cr && i_text_byte == C_LF) begin
            o_after_cr = 1'b0;
        end else if (i_text_byte == C_LF) begin
            o_line   = line_inc;
            o_column = '0;
        end else if (i_text_byte == C_CR) begin
            o_line     = line_inc;
            o_column   = '0;
            o_after_cr = 1'b1;
        end else begin
            o_column  = column_inc;
            o_swallow = i_lead.swallow;
        end
    end

    generate
        if (COUNT_WIDTH > OUT_WIDTH) begin : g_clamp
            assign o_line_clamped   = (|o_line[COUNT_WIDTH-1:OUT_WIDTH])
                                      ? '1 : o_line[OUT_WIDTH-1:0];
            assign o_column_clamped = (|o_column[COUNT_WIDTH-1:OUT_WIDTH])
                                      ? '1 : o_column[OUT_WIDTH-1:0];
        end else begin : g_extend
            assign o_line_clamped   = OUT_WIDTH'(o_line);
            assign o_column_clamped = OUT_WIDTH'(o_column);
        end
    endgenerate

endmodule

// File: rtl/u8u16_checker.sv
// Port-level checks of the position core, bound to its top level.
`include "utf8_offset_to_utf16_position_core_defines.svh"

module u8u16_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            o_in_stall,
    input  logic                            o_out_valid,
    input  logic                            i_out_stall,
    input  logic [u8u16_pkg::OUT_WIDTH-1:0] o_line_number,
    input  logic [u8u16_pkg::OUT_WIDTH-1:0] o_utf16_column,
    input  logic                            o_answer_ready
);

    // A stalled result keeps its payload.
    `U8U16_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_line_number) && $stable(o_utf16_column) && $stable(o_answer_ready), "stalled result changed")

    // Reset empties the core.
    `U8U16_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid && !o_in_stall, "core not empty after reset")

    // Input stall is only raised when the result side is backed up.
    `U8U16_ASSERT(a_stall_cause, i_clk, i_rst_n, o_in_stall |-> o_out_valid && i_out_stall, "input stalled without output backpressure")

    // After an input transfer, a result is on offer once the byte has passed the input register.
    `U8U16_ASSERT(a_result_due, i_clk, i_rst_n, i_in_valid && !o_in_stall |=> ##1 o_out_valid, "no result two cycles after input transfer")

endmodule

bind utf8_offset_to_utf16_position_core u8u16_checker u_checker (.*);

// File: bench/u8u16_position_tb_pkg.sv
// Scoreboard class that predicts and checks the line and column results of the position core.
`timescale 1ns / 100ps

package u8u16_position_tb_pkg;

    import u8u16_pkg::*;

    typedef struct packed {
        logic [OUT_WIDTH-1:0] line_number;
        logic [OUT_WIDTH-1:0] utf16_column;
        logic                 answer_ready;
    } t_position;

    class t_position_scoreboard #(int CW = 32);

        bit [CW-1:0] lines_seen;
        bit [CW-1:0] units_on_line;
        bit [1:0]    cont_left;
        bit          cr_pending;
        t_position   awaited[$];
        int unsigned mismatches;

        function new();
            clear_text();
            mismatches = 0;
        endfunction

        function void clear_text();
            lines_seen    = '0;
            units_on_line = '0;
            cont_left     = '0;
            cr_pending    = 1'b0;
        endfunction

        // Counters stick at their maximum instead of wrapping.
        function bit [CW-1:0] add_sat(bit [CW-1:0] a, bit [1:0] b);
            bit [CW:0] s;
            s = {1'b0, a} + b;
            return s[CW] ? '1 : s[CW-1:0];
        endfunction

        function logic [OUT_WIDTH-1:0] to_port(bit [CW-1:0] v);
            bit [63:0] w;
            w = 64'(v);
            return (w > 64'hFFFF_FFFF) ? '1 : w[OUT_WIDTH-1:0];
        endfunction

        // Advances the line and column state by one accepted byte.
        function void note_byte(logic [7:0] cur, logic [7:0] nxt, logic [1:0] after,
                                logic start, logic qend);
            bit [1:0]  units;
            t_position want;
            if (start) begin
                clear_text();
            end
            if (cont_left != 0) begin
                cont_left = cont_left - 1'b1;
            end else if (cr_pending && cur == C_LF) begin
                cr_pending = 1'b0;
            end else begin
                cr_pending = 1'b0;
                if (cur == C_LF || cur == C_CR) begin
                    lines_seen    = add_sat(lines_seen, 2'd1);
                    units_on_line = '0;
                    cr_pending    = (cur == C_CR);
                end else begin
                    units = 2'd1;
                    if ((cur & C_MASK_LEAD2) == C_CODE_LEAD2 && after >= 2'd1) begin
                        cont_left = 2'd1;
                    end else if ((cur & C_MASK_LEAD3) == C_CODE_LEAD3 && after >= 2'd2) begin
                        cont_left = 2'd2;
                    end else if ((cur & C_MASK_LEAD4) == C_CODE_LEAD4 && after == 2'd3) begin
                        cont_left = 2'd3;
                        // Planes above the basic one need a surrogate pair.
                        if ((cur & C_PLANE_MASK) != 0 || (nxt & C_CONT_MASK) >= C_PLANE_MIN) begin
                            units = 2'd2;
                        end
                    end
                    units_on_line = add_sat(units_on_line, units);
                end
            end
            want.line_number  = to_port(lines_seen);
            want.utf16_column = to_port(units_on_line);
            want.answer_ready = qend;
            awaited.push_back(want);
        endfunction

        function void check_position(logic [OUT_WIDTH-1:0] line, logic [OUT_WIDTH-1:0] col,
                                     logic ans);
            t_position want;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: unexpected result line %0d column %0d answer %0b",
                             $realtime, line, col, ans);
                end
                return;
            end
            want = awaited.pop_front();
            if (line !== want.line_number || col !== want.utf16_column
                    || ans !== want.answer_ready) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: expected line %0d column %0d answer %0b, got %0d %0d %0b",
                             $realtime, want.line_number, want.utf16_column,
                             want.answer_ready, line, col, ans);
                end
            end
        endfunction

    endclass

endpackage

// File: bench/tb_utf8_offset_to_utf16_position_core.sv
// Top-level testbench for the UTF-8 offset to UTF-16 position core.
`timescale 1ns / 100ps

// The bench streams UTF-8 texts through the core one byte per transfer and
// checks every result transfer against a scoreboard that tracks lines, UTF-16
// columns, pending continuation bytes and a pending CR on its own. The core
// is built with 16-bit counters, narrower than its 32-bit outputs.
module tb_utf8_offset_to_utf16_position_core;

    import u8u16_pkg::*;
    import u8u16_position_tb_pkg::*;

    // Counter width of the core under test, narrower than the output ports.
    localparam int CW = 16;
    // Cycles without any transfer on either side before the run is abandoned.
    localparam int QUIET_LIMIT = 1000;
    // Length of the receiver's long hold-off, in cycles.
    localparam int HOLD_CYCLES = 80;
    // Number of bytes after which the random part stops.
    localparam int RANDOM_BYTES = 1000;

    typedef logic [7:0] t_byte_q[$];
    typedef t_position_scoreboard #(CW) t_board;

    logic                 i_clk            = 1'b0;
    logic                 i_rst_n          = 1'b0;
    logic                 i_in_valid       = 1'b0;
    logic                 o_in_stall;
    logic [7:0]           i_text_byte      = '0;
    logic [7:0]           i_following_byte = '0;
    logic [1:0]           i_bytes_after    = '0;
    logic                 i_start_of_text  = 1'b0;
    logic                 i_query_end      = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall      = 1'b0;
    logic [OUT_WIDTH-1:0] o_line_number;
    logic [OUT_WIDTH-1:0] o_utf16_column;
    logic                 o_answer_ready;

    t_board board = new();

    // Idle and stall rates in percent; the stimulus lowers them to zero for
    // a stretch so the core also sees back-to-back traffic.
    int unsigned sender_idle_pct    = 15;
    int unsigned receiver_stall_pct = 15;
    // Set by the stimulus to ask the receiver for one long hold-off.
    int unsigned hold_request       = 0;
    int unsigned bytes_sent         = 0;
    int unsigned quiet_cycles       = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    utf8_offset_to_utf16_position_core #(
        .COUNT_WIDTH(CW)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_text_byte     (i_text_byte),
        .i_following_byte(i_following_byte),
        .i_bytes_after   (i_bytes_after),
        .i_start_of_text (i_start_of_text),
        .i_query_end     (i_query_end),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_line_number   (o_line_number),
        .o_utf16_column  (o_utf16_column),
        .o_answer_ready  (o_answer_ready)
    );

    // Both channels are observed in one block so that an input transfer is
    // always predicted before a result at the same edge is checked. Every
    // signal read here was driven by a nonblocking assignment, so the values
    // seen are those present at the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            board.note_byte(i_text_byte, i_following_byte, i_bytes_after,
                            i_start_of_text, i_query_end);
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            board.check_position(o_line_number, o_utf16_column, o_answer_ready);
        end
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // The receiver stalls at random, and once on request holds the result
    // channel off for a long stretch that it counts itself. During that
    // stretch the sender keeps offering bytes, so both internal registers
    // fill and the core has to raise its input stall.
    initial begin : receiver
        int unsigned held;
        held = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request != 0) begin
                held         = hold_request;
                hold_request = 0;
            end
            if (held != 0) begin
                held--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < receiver_stall_pct);
            end
        end
    end

    // Offers one byte and returns at the edge where it is accepted. Valid is
    // left high so the next byte can follow without a gap, and the payload
    // is never touched while the core stalls it.
    task automatic offer_byte(input logic [7:0] cur, input logic [7:0] nxt,
                              input logic [1:0] after, input logic start, input logic qend);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_text_byte      <= cur;
        i_following_byte <= nxt;
        i_bytes_after    <= after;
        i_start_of_text  <= start;
        i_query_end      <= qend;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        bytes_sent++;
    endtask

    // Holds the input channel idle until every predicted result has arrived.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (board.awaited.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Walks a buffer from its first byte up to the queried offset. The
    // following byte and the remaining count come from the buffer itself;
    // past its end the following byte is junk, as it would be in memory.
    // The last byte carries the query mark, and a few others get a stray one.
    task automatic send_text(input t_byte_q txt, input int unsigned offset);
        logic [7:0]  nxt;
        logic [1:0]  after;
        int unsigned left;
        for (int i = 0; i < offset; i++) begin
            nxt   = (i + 1 < txt.size()) ? txt[i+1] : 8'($urandom);
            left  = txt.size() - 1 - i;
            after = (left > 3) ? 2'd3 : 2'(left);
            offer_byte(txt[i], nxt, after, i == 0,
                       (i == offset - 1) || ($urandom_range(19) == 0));
        end
    endtask

    // Returns a continuation byte, now and then replaced by any byte at all
    // since the core swallows whatever follows a lead.
    function automatic logic [7:0] cont_byte();
        if ($urandom_range(19) == 0) begin
            return 8'($urandom);
        end
        return 8'h80 | 8'($urandom_range(63));
    endfunction

    // Appends one character: mostly well-formed UTF-8 and line breaks, with
    // some stray continuation bytes, invalid leads and raw random bytes.
    function automatic void append_char(ref t_byte_q txt);
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 30) begin
            txt.push_back(8'($urandom_range(8'h7F)));
        end else if (pick < 40) begin
            txt.push_back(C_LF);
        end else if (pick < 47) begin
            txt.push_back(C_CR);
        end else if (pick < 53) begin
            txt.push_back(C_CR);
            txt.push_back(C_LF);
        end else if (pick < 63) begin
            txt.push_back(8'($urandom_range(8'hC0, 8'hDF)));
            txt.push_back(cont_byte());
        end else if (pick < 73) begin
            txt.push_back(8'($urandom_range(8'hE0, 8'hEF)));
            txt.push_back(cont_byte());
            txt.push_back(cont_byte());
        end else if (pick < 84) begin
            txt.push_back(8'($urandom_range(8'hF0, 8'hF7)));
            txt.push_back(cont_byte());
            txt.push_back(cont_byte());
            txt.push_back(cont_byte());
        end else if (pick < 89) begin
            txt.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end else if (pick < 93) begin
            txt.push_back(8'($urandom_range(8'hF8, 8'hFF)));
        end else begin
            txt.push_back(8'($urandom));
        end
    endfunction

    // Builds one random text, sometimes cut short so that a multi-byte lead
    // runs past the buffer end, and queries either its end or an offset
    // somewhere inside it.
    task automatic play_random_text();
        t_byte_q     txt;
        int unsigned chars;
        int unsigned cut;
        int unsigned offset;
        chars = ($urandom_range(9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
        repeat (chars) begin
            append_char(txt);
        end
        cut = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
        while (cut != 0 && txt.size() > 1) begin
            txt.delete(txt.size() - 1);
            cut--;
        end
        offset = ($urandom_range(1) == 0) ? txt.size() : $urandom_range(1, txt.size());
        send_text(txt, offset);
    endtask

    initial begin : stimulus
        t_byte_q txt;
        bit      held_off;
        bit      paused;
        held_off = 1'b0;
        paused   = 1'b0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed text: the lowest byte, the top ASCII byte, an invalid
        // lead, a stray continuation, LF, the CR-LF pair, two lone CRs, a
        // two-byte character, a three-byte lead whose swallowed bytes are LF
        // and CR, a four-byte character beyond the basic plane, one that is
        // beyond it only by its lead bits, and one whose code point stays
        // below it.
        txt = '{8'h00, 8'h7F, 8'hFF, 8'h80, C_LF, C_CR, C_LF, C_CR, C_CR,
                8'hC3, 8'hA9, 8'hE2, C_LF, C_CR,
                8'hF0, 8'h9F, 8'h98, 8'h80, 8'hF1, 8'h80, 8'h80, 8'h80,
                8'hF0, 8'h8F, 8'hBF, 8'hBF};
        send_text(txt, txt.size());
        // A three-byte lead that the buffer end cuts off counts on its own.
        txt = '{8'hE2, 8'h82};
        send_text(txt, txt.size());

        // Random texts with some fully random bytes in between.
        while (bytes_sent < RANDOM_BYTES) begin
            if ((bytes_sent >= 250 && bytes_sent < 420) || (bytes_sent >= 500 && bytes_sent < 560)) begin
                sender_idle_pct = 0;
            end else begin
                sender_idle_pct = 15;
            end
            receiver_stall_pct = (bytes_sent >= 250 && bytes_sent < 420) ? 0 : 15;
            if (!held_off && bytes_sent >= 500) begin
                held_off     = 1'b1;
                hold_request = HOLD_CYCLES;
            end
            if (!paused && bytes_sent >= 750) begin
                paused = 1'b1;
                wait_for_results();
            end
            if ($urandom_range(11) == 0) begin
                offer_byte(8'($urandom), 8'($urandom), 2'($urandom), 1'($urandom),
                           1'($urandom));
            end else begin
                play_random_text();
            end
        end
        sender_idle_pct    = 15;
        receiver_stall_pct = 15;

        // Drain, then give the two-stage pipeline a few extra edges to show
        // any result that was never asked for.
        wait_for_results();
        repeat (8) @(posedge i_clk);
        if (board.mismatches == 0 && board.awaited.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/u8u16_pkg.sv
rtl/u8u16_lead.sv
rtl/u8u16_step.sv
rtl/utf8_offset_to_utf16_position_core.sv
rtl/u8u16_checker.sv
bench/u8u16_position_tb_pkg.sv
bench/tb_utf8_offset_to_utf16_position_core.sv
